// ----- rtl/core/prtt_pkg.sv -----
// Shared types and constants of the pending request tag table.
package prtt_pkg;

    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int TAG_W  = 32;
    localparam int DIG_W  = 60;
    localparam int LEN_W  = 4;
    localparam int HAN_W  = 16;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 112;

    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd1;
    localparam logic [OP_W-1:0] OP_TAKE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

    localparam logic [TAG_W-1:0] TAG_START = 32'h0000_0100;

    // Result of the tag search and the free slot search.
    typedef struct packed {
        logic hit;
        logic full;
    } t_match_flags;

    // Update of the slot valid bits and tags.
    typedef struct packed {
        logic set;
        logic clr;
    } t_slot_cmd;

endpackage

// ----- rtl/core/prtt_match.sv -----
// Slot valid bits and tags in flops, with the tag search and the free slot search.
module prtt_match #(
    parameter int ENTRIES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [prtt_pkg::TAG_W-1:0]    i_lookup_tag,
    input  prtt_pkg::t_slot_cmd           i_cmd,
    input  logic [$clog2(ENTRIES)-1:0]    i_upd_idx,
    input  logic [prtt_pkg::TAG_W-1:0]    i_upd_tag,
    output prtt_pkg::t_match_flags        o_flags,
    output logic [$clog2(ENTRIES)-1:0]    o_hit_idx,
    output logic [$clog2(ENTRIES)-1:0]    o_free_idx
);
    import prtt_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    logic [ENTRIES-1:0] r_valid;
    logic [TAG_W-1:0]   r_slot_tag [ENTRIES];
    logic [ENTRIES-1:0] w_match;
    logic [ENTRIES-1:0] w_free;
    logic [ENTRIES-1:0] w_match_low;
    logic [ENTRIES-1:0] w_free_low;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_slot_tag[i] == i_lookup_tag);
        end
        w_free      = ~r_valid;
        // Isolate the lowest set bit so that the index is a plain OR tree.
        w_match_low = w_match & (~w_match + 1'b1);
        w_free_low  = w_free & (~w_free + 1'b1);
        o_hit_idx   = '0;
        o_free_idx  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_match_low[i]) begin
                o_hit_idx = o_hit_idx | IW'(i);
            end
            if (w_free_low[i]) begin
                o_free_idx = o_free_idx | IW'(i);
            end
        end
        o_flags.hit  = |w_match;
        o_flags.full = &r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (i_upd_idx == IW'(i)) begin
                    if (i_cmd.set) begin
                        r_valid[i] <= 1'b1;
                    end else if (i_cmd.clr) begin
                        r_valid[i] <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_cmd.set && (i_upd_idx == IW'(i))) begin
                r_slot_tag[i] <= i_upd_tag;
            end
        end
    end

endmodule

// ----- rtl/core/prtt_store.sv -----
// Payload memory of the slots: subscriber digits, digit count and answer handle.
module prtt_store #(
    parameter int ENTRIES = 32,
    parameter int WIDTH   = 80
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic                       i_rd_en,
    input  logic [$clog2(ENTRIES)-1:0] i_addr,
    input  logic [WIDTH-1:0]           i_wr_data,
    output logic [WIDTH-1:0]           o_rd_data
);
    logic [WIDTH-1:0] r_mem [ENTRIES];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/pending_request_tag_table_top.sv -----
// Top level of the pending request tag table: sequencer, tag counter and result register.
//
// One transaction on the slave stream carries a request: tuser holds the operation
// (add, peek or take) and tdata the lookup tag, subscriber number, digit count and
// answer handle. Every request yields exactly one transaction on the master stream,
// with the status in tuser and the given tag, found number, count and handle in tdata.
// An add takes the lowest free slot and a fresh tag from a counter that starts at
// 0x100 and skips back to 0x100 after 0xFFFFFFFF. Peek returns the number stored
// under a tag; take returns the handle and frees the slot.
// A request passes through the tag search state, which runs over the tags and valid
// bits held in flops and issues the payload memory access, and then the registered
// memory read state, in which the result register is loaded and the next request
// is accepted. The block does not take a new request before it has loaded the
// result of the last one.
// The result register decouples the two sides: a request is still taken while a
// result waits, and the block then holds the next result until the master side
// accepts. Reset clears all slot valid bits at once and sets the counter to 0x100;
// there is no clearing pass, so a request may follow right after reset.
module pending_request_tag_table_top #(
    parameter int ENTRIES     = 32,
    parameter int MAX_DIGITS  = 15,
    parameter int HANDLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // From bit 0: lookup_tag[31:0], subscriber_digits[91:32], subscriber_length[95:92],
    // answer_handle[111:96].
    input  logic [prtt_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // Fields: operation[1:0].
    input  logic [prtt_pkg::OP_W-1:0]         i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // From bit 0: given_tag[31:0], found_digits[91:32], found_length[95:92],
    // found_handle[111:96].
    output logic [prtt_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // Fields: status[1:0].
    output logic [prtt_pkg::STAT_W-1:0]       o_m_axis_tuser
);
    import prtt_pkg::*;

    localparam int IW  = $clog2(ENTRIES);
    localparam int SHB = (HANDLE_BITS < HAN_W) ? HANDLE_BITS : HAN_W;
    localparam int PW  = DIG_W + LEN_W + SHB;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'((MAX_DIGITS > 15) ? 15 : MAX_DIGITS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [TAG_W-1:0]  r_next_tag;
    logic [TAG_W-1:0]  n_next_tag;
    logic              r_out_valid;

    // Request held for the search cycle.
    logic [OP_W-1:0]   r_op;
    logic [TAG_W-1:0]  r_tag;
    logic [DIG_W-1:0]  r_dig;
    logic [LEN_W-1:0]  r_len;
    logic [HAN_W-1:0]  r_han;

    // Outcome of the search, held for the memory read cycle.
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic [TAG_W-1:0]  r_given;
    logic              r_peek_hit;
    logic              r_take_hit;

    // Result register.
    logic [STAT_W-1:0] r_out_status;
    logic [TAG_W-1:0]  r_out_given;
    logic [DIG_W-1:0]  r_out_dig;
    logic [LEN_W-1:0]  r_out_len;
    logic [HAN_W-1:0]  r_out_han;

    logic              w_in_acc;
    logic              w_out_free;
    logic              w_load_out;
    logic              w_look;
    logic              w_add_ok;
    logic              w_peek_hit;
    logic              w_take_hit;
    logic [LEN_W-1:0]  w_len_sat;
    logic [TAG_W-1:0]  w_tag_inc;

    t_match_flags      w_flags;
    t_slot_cmd         w_cmd;
    logic [IW-1:0]     w_hit_idx;
    logic [IW-1:0]     w_free_idx;
    logic [IW-1:0]     w_idx;
    logic [PW-1:0]     w_wr_data;
    logic [PW-1:0]     w_rd_data;

    // The result register is free when empty or when its transaction completes now.
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_load_out = (r_state == S_RESP) && w_out_free;
    assign o_s_axis_tready = (r_state == S_IDLE) || w_load_out;
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_look = (r_state == S_LOOK);

    assign w_add_ok   = (r_op == OP_ADD) && !w_flags.full;
    assign w_peek_hit = (r_op == OP_PEEK) && w_flags.hit;
    assign w_take_hit = (r_op == OP_TAKE) && w_flags.hit;

    assign w_cmd.set = w_look && w_add_ok;
    assign w_cmd.clr = w_look && w_take_hit;
    assign w_idx     = (r_op == OP_ADD) ? w_free_idx : w_hit_idx;

    assign w_len_sat = (r_len > LEN_CAP) ? LEN_CAP : r_len;
    assign w_wr_data = {r_dig, w_len_sat, r_han[SHB-1:0]};
    assign w_tag_inc = r_next_tag + 1'b1;

    prtt_match #(
        .ENTRIES (ENTRIES)
    ) u_match (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_lookup_tag (r_tag),
        .i_cmd        (w_cmd),
        .i_upd_idx    (w_idx),
        .i_upd_tag    (r_next_tag),
        .o_flags      (w_flags),
        .o_hit_idx    (w_hit_idx),
        .o_free_idx   (w_free_idx)
    );

    prtt_store #(
        .ENTRIES (ENTRIES),
        .WIDTH   (PW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_look && w_add_ok),
        .i_rd_en   (w_look && (w_peek_hit || w_take_hit)),
        .i_addr    (w_idx),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        unique case (r_op)
            OP_ADD:  n_status = w_flags.full ? ST_FULL : ST_OK;
            OP_PEEK: n_status = w_flags.hit ? ST_OK : ST_MISS;
            OP_TAKE: n_status = w_flags.hit ? ST_OK : ST_MISS;
            default: n_status = ST_MISS;
        endcase
    end

    always_comb begin
        n_next_tag = r_next_tag;
        if (w_look && w_add_ok) begin
            // The counter never hands out zero: it restarts at the base tag.
            n_next_tag = (w_tag_inc == '0) ? TAG_START : w_tag_inc;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: n_state = S_RESP;
            S_RESP: begin
                if (w_load_out) begin
                    n_state = w_in_acc ? S_LOOK : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_tag  <= TAG_START;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_next_tag <= n_next_tag;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op  <= i_s_axis_tuser;
            r_tag <= i_s_axis_tdata[31:0];
            r_dig <= i_s_axis_tdata[91:32];
            r_len <= i_s_axis_tdata[95:92];
            r_han <= i_s_axis_tdata[111:96];
        end
        if (w_look) begin
            r_status   <= n_status;
            r_given    <= w_add_ok ? r_next_tag : '0;
            r_peek_hit <= w_peek_hit;
            r_take_hit <= w_take_hit;
        end
        if (w_load_out) begin
            r_out_status <= r_status;
            r_out_given  <= r_given;
            r_out_dig    <= r_peek_hit ? w_rd_data[PW-1 -: DIG_W] : '0;
            r_out_len    <= r_peek_hit ? w_rd_data[SHB +: LEN_W] : '0;
            r_out_han    <= r_take_hit ? HAN_W'(w_rd_data[SHB-1:0]) : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {r_out_han, r_out_len, r_out_dig, r_out_given};

`ifndef NO_ASSERTIONS
    a_look_then_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOOK |=> r_state == S_RESP)
        else $error("search cycle not followed by memory read cycle");

    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == S_LOOK)
        else $error("accepted request did not enter the search cycle");

    a_tag_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_tag >= TAG_START)
        else $error("tag counter fell below its base value");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != ST_OK) |-> o_m_axis_tdata == '0)
        else $error("failed request returned nonzero data");

    a_ok_add_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == ST_OK) && (r_out_given != '0)
        |-> (r_out_dig == '0) && (r_out_han == '0))
        else $error("successful add returned lookup data");
`endif

endmodule

// ----- bench/pending_request_tag_table_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the pending request tag table, with a shadow model of the slots.
module pending_request_tag_table_top_tb;

    import prtt_pkg::*;

    localparam int ENTRIES     = 32;
    localparam int MAX_DIGITS  = 15;
    localparam int HANDLE_BITS = 16;

    localparam int ITEMS       = 1850;
    localparam int STUCK_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 10;

    // The package names three operations; the fourth code is accepted and answered as a miss.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int LEN_CAP = (MAX_DIGITS > 15) ? 15 : MAX_DIGITS;
    localparam logic [HAN_W-1:0] HANDLE_MASK = HAN_W'((64'd1 << HANDLE_BITS) - 64'd1);

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [TAG_W-1:0] tag;
        logic [DIG_W-1:0] digits;
        logic [LEN_W-1:0] len;
        logic [HAN_W-1:0] handle;
    } t_request;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TAG_W-1:0]  given;
        logic [DIG_W-1:0]  digits;
        logic [LEN_W-1:0]  len;
        logic [HAN_W-1:0]  handle;
    } t_answer;

    typedef struct packed {
        logic [ENTRIES-1:0]            valid;
        logic [ENTRIES-1:0][TAG_W-1:0] tags;
        logic [ENTRIES-1:0][DIG_W-1:0] digits;
        logic [ENTRIES-1:0][LEN_W-1:0] lens;
        logic [ENTRIES-1:0][HAN_W-1:0] handles;
        logic [TAG_W-1:0]              next_tag;
    } t_tag_table;

    // Traffic mixes of the random part.
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE} t_mix;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [OP_W-1:0]       s_tuser  = '0;
    logic                  m_tready = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]     m_tuser;

    // Requests waiting for the driver, and responses the block still owes.
    t_request outbox[$];
    t_answer  answers_due[$];

    // The plan copy steers stimulus generation; the live copy predicts from what was accepted.
    t_tag_table       plan_tbl;
    t_tag_table       live_tbl;
    logic [TAG_W-1:0] last_freed_tag = '0;

    int planned_items  = 0;
    int counted_items  = 0;
    int accepted_items = 0;
    int mismatches     = 0;
    int n_adds = 0, n_full = 0, n_peek_hits = 0, n_take_hits = 0, n_misses = 0;
    int peak_fill = 0;

    bit in_fire = 1'b0;
    bit out_fire = 1'b0;
    int stuck_cycles = 0;
    int burst_left = 0, gap_left = 0;
    int ready_mode = 0, ready_left = 0, ready_duty = 0;

    t_request drive_req;
    t_request seen_req;
    t_answer  due_ans;
    t_answer  new_ans;

    pending_request_tag_table_top #(
        .ENTRIES    (ENTRIES),
        .MAX_DIGITS (MAX_DIGITS),
        .HANDLE_BITS(HANDLE_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser)
    );

    // Applies one request to a copy of the slot table and works out the response.
    task automatic serve_request(inout t_tag_table tbl, input t_request req,
                                 output t_answer ans);
        int i;
        int slot;
        ans = '0;
        ans.status = ST_MISS;
        slot = -1;
        if (req.op == OP_ADD) begin
            ans.status = ST_FULL;
            for (i = ENTRIES - 1; i >= 0; i--)
                if (!tbl.valid[i]) slot = i;
            if (slot >= 0) begin
                ans.status = ST_OK;
                ans.given = tbl.next_tag;
                tbl.valid[slot]   = 1'b1;
                tbl.tags[slot]    = tbl.next_tag;
                tbl.digits[slot]  = req.digits;
                tbl.lens[slot]    = (req.len > LEN_CAP) ? LEN_W'(LEN_CAP) : req.len;
                tbl.handles[slot] = req.handle & HANDLE_MASK;
                // The counter never hands out zero: past the top it restarts at the base.
                tbl.next_tag = tbl.next_tag + 1'b1;
                if (tbl.next_tag == '0) tbl.next_tag = TAG_START;
            end
        end else if (req.op == OP_PEEK || req.op == OP_TAKE) begin
            // The lowest matching slot wins when two carry the same tag.
            for (i = ENTRIES - 1; i >= 0; i--)
                if (tbl.valid[i] && tbl.tags[i] == req.tag) slot = i;
            if (slot >= 0) begin
                ans.status = ST_OK;
                if (req.op == OP_PEEK) begin
                    ans.digits = tbl.digits[slot];
                    ans.len    = tbl.lens[slot];
                end else begin
                    ans.handle = tbl.handles[slot];
                    tbl.valid[slot] = 1'b0;
                end
            end
        end
    endtask

    task automatic queue_request(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag,
                                 input logic [DIG_W-1:0] digits,
                                 input logic [LEN_W-1:0] len,
                                 input logic [HAN_W-1:0] handle);
        t_request req;
        t_answer  ans;
        req.op     = op;
        req.tag    = tag;
        req.digits = digits;
        req.len    = len;
        req.handle = handle;
        serve_request(plan_tbl, req, ans);
        if (op == OP_TAKE && ans.status == ST_OK) last_freed_tag = tag;
        outbox.push_back(req);
        planned_items++;
        if (op != OP_UNUSED) counted_items++;
    endtask

    function automatic logic [TAG_W-1:0] pick_live_tag(input t_tag_table tbl);
        int i;
        int k;
        logic [TAG_W-1:0] tag;
        k = $urandom_range(0, $countones(tbl.valid) - 1);
        tag = '0;
        for (i = 0; i < ENTRIES; i++) begin
            if (tbl.valid[i]) begin
                if (k == 0) tag = tbl.tags[i];
                k--;
            end
        end
        return tag;
    endfunction

    // Tags that should miss, many of them close to ones the block has seen.
    function automatic logic [TAG_W-1:0] stray_tag(input t_tag_table tbl,
                                                   input logic [TAG_W-1:0] freed);
        logic [TAG_W-1:0] tag;
        case ($urandom_range(0, 5))
            0: tag = tbl.next_tag;
            1: tag = freed;
            2: tag = '0;
            3: tag = '1;
            4: begin
                tag = $urandom;
                if (tbl.valid != '0)
                    tag = pick_live_tag(tbl) ^ (32'd1 << $urandom_range(0, TAG_W - 1));
            end
            default: tag = $urandom;
        endcase
        return tag;
    endfunction

    function automatic logic [DIG_W-1:0] any_digits();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: raw = '1;
            1: raw = '0;
            default: ;
        endcase
        return raw[DIG_W-1:0];
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Sender: new requests go out at the falling edge, in bursts separated by random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n && (in_fire || !s_tvalid)) begin
            if (gap_left > 0 || outbox.size() == 0) begin
                if (gap_left > 0) gap_left--;
                s_tvalid <= 1'b0;
            end else begin
                drive_req = outbox.pop_front();
                s_tdata  <= {drive_req.handle, drive_req.len, drive_req.digits, drive_req.tag};
                s_tuser  <= drive_req.op;
                s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25)
                                                          : $urandom_range(0, 3);
                end
            end
        end
    end

    // Receiver: alternates between always ready, a random duty cycle and a hard stall.
    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(4, 40);
            ready_duty = $urandom_range(1, 7);
        end else begin
            ready_left--;
        end
        case (ready_mode)
            2:       m_tready <= ($urandom_range(0, 7) < ready_duty);
            3:       m_tready <= 1'b0;
            default: m_tready <= 1'b1;
        endcase
    end

    // Monitor: checks responses and predicts accepted requests at the rising edge.
    always @(posedge i_clk) begin
        in_fire  = 1'b0;
        out_fire = 1'b0;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                out_fire = 1'b1;
                if (answers_due.size() == 0) begin
                    $error("response transaction with no request outstanding");
                    mismatches++;
                end else begin
                    due_ans = answers_due.pop_front();
                    compare_field("status",       due_ans.status, m_tuser);
                    compare_field("given_tag",    due_ans.given,  m_tdata[31:0]);
                    compare_field("found_digits", due_ans.digits, m_tdata[91:32]);
                    compare_field("found_length", due_ans.len,    m_tdata[95:92]);
                    compare_field("found_handle", due_ans.handle, m_tdata[111:96]);
                end
            end
            if (s_tvalid && s_tready) begin
                in_fire = 1'b1;
                seen_req.op     = s_tuser;
                seen_req.tag    = s_tdata[31:0];
                seen_req.digits = s_tdata[91:32];
                seen_req.len    = s_tdata[95:92];
                seen_req.handle = s_tdata[111:96];
                serve_request(live_tbl, seen_req, new_ans);
                answers_due.push_back(new_ans);
                accepted_items++;
                if (seen_req.op == OP_ADD) n_adds++;
                if (new_ans.status == ST_FULL) n_full++;
                if (new_ans.status == ST_MISS) n_misses++;
                if (new_ans.status == ST_OK && seen_req.op == OP_PEEK) n_peek_hits++;
                if (new_ans.status == ST_OK && seen_req.op == OP_TAKE) n_take_hits++;
                if ($countones(live_tbl.valid) > peak_fill) peak_fill = $countones(live_tbl.valid);
            end
        end
        if (in_fire || out_fire) stuck_cycles = 0;
        else stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $error("no transaction on either side for %0d cycles", STUCK_LIMIT);
            $display("pending_request_tag_table_top test failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_mix             mix;
        int               mix_left;
        int               roll;
        logic [OP_W-1:0]  op;
        logic [TAG_W-1:0] tag;

        plan_tbl = '0;
        plan_tbl.next_tag = TAG_START;
        live_tbl = plan_tbl;

        // Directed part: misses on an empty table, the unused code, field extremes,
        // handle zero, non-BCD digits, slot reuse after a take, and draining to empty.
        queue_request(OP_PEEK,   TAG_START, '0, '0, '0);
        queue_request(OP_TAKE,   '1, '1, '1, '1);
        queue_request(OP_UNUSED, '1, '1, '1, '1);
        queue_request(OP_UNUSED, '0, '0, '0, '0);
        queue_request(OP_ADD,    '1, '1, 4'd15, 16'hFFFF);
        queue_request(OP_ADD,    '0, '0, 4'd0, 16'h0000);
        queue_request(OP_ADD,    '0, 60'h123456789012345, 4'd11, 16'h8001);
        queue_request(OP_ADD,    '0, 60'hABCDEF0FEDCBA98, 4'd5, 16'h7FFE);
        queue_request(OP_PEEK,   TAG_START, '0, '0, '0);
        queue_request(OP_PEEK,   TAG_START + 1, '0, '0, '0);
        queue_request(OP_PEEK,   TAG_START + 4, '0, '0, '0);
        queue_request(OP_TAKE,   TAG_START + 1, '0, '0, '0);
        queue_request(OP_TAKE,   TAG_START + 1, '0, '0, '0);
        queue_request(OP_PEEK,   TAG_START + 1, '0, '0, '0);
        queue_request(OP_ADD,    '0, 60'h000000000000009, 4'd1, 16'h1234);
        queue_request(OP_PEEK,   TAG_START + 4, '0, '0, '0);
        queue_request(OP_TAKE,   TAG_START, '0, '0, '0);
        queue_request(OP_TAKE,   '0, '0, '0, '0);
        queue_request(OP_PEEK,   TAG_START + 2, '0, '0, '0);
        queue_request(OP_TAKE,   TAG_START + 2, '0, '0, '0);
        queue_request(OP_TAKE,   TAG_START + 3, '0, '0, '0);
        queue_request(OP_TAKE,   TAG_START + 4, '0, '0, '0);

        // Random part. Most peeks and takes carry a live tag; the opening fill episode
        // runs long enough to hit a full table. The counter wraps only after about four
        // billion adds, so the wrap and the duplicate tags it allows stay out of reach.
        mix = MIX_FILL;
        mix_left = 70;
        while (counted_items < ITEMS) begin
            if (mix_left == 0) begin
                mix = t_mix'($urandom_range(0, 3));
                mix_left = $urandom_range(10, 80);
            end
            mix_left--;
            roll = $urandom_range(0, 99);
            case (mix)
                MIX_FILL:  op = (roll < 70) ? OP_ADD : (roll < 85) ? OP_PEEK :
                                (roll < 95) ? OP_TAKE : OP_UNUSED;
                MIX_DRAIN: op = (roll < 15) ? OP_ADD : (roll < 30) ? OP_PEEK :
                                (roll < 95) ? OP_TAKE : OP_UNUSED;
                MIX_BALANCED: op = (roll < 34) ? OP_ADD : (roll < 64) ? OP_PEEK :
                                   (roll < 96) ? OP_TAKE : OP_UNUSED;
                default:   op = OP_W'($urandom_range(0, 3));
            endcase
            if (mix == MIX_NOISE || plan_tbl.valid == '0 || $urandom_range(0, 6) == 0)
                tag = stray_tag(plan_tbl, last_freed_tag);
            else
                tag = pick_live_tag(plan_tbl);
            queue_request(op, tag, any_digits(), LEN_W'($urandom_range(0, 15)),
                          HAN_W'($urandom_range(0, 65535)));
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_items < planned_items || answers_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("Ran %0d requests: %0d adds (%0d refused on a full table), %0d peek hits,",
                 accepted_items, n_adds, n_full, n_peek_hits);
        $display("%0d take hits, %0d misses; peak occupancy %0d of %0d slots.",
                 n_take_hits, n_misses, peak_fill, ENTRIES);
        if (mismatches == 0) begin
            $display("pending_request_tag_table_top test passed");
        end else begin
            $display("pending_request_tag_table_top test failed");
        end
        $finish;
    end

endmodule
